FILE: rtl/ecgrhr_pkg.sv
// Shared types, constants and register codes of the ECG R-peak heart-rate detector.
`timescale 1ns / 1ps
package ecgrhr_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int TIME_BITS       = 32;
    localparam int THR_BITS        = 12;
    localparam int MINRR_BITS      = 16;
    localparam int CFG_DATA_BITS   = 16;
    localparam int CFG_IDX_BITS    = 1;
    localparam int RATE_BITS       = 16;
    localparam int DIV_CNT_BITS    = $clog2(RATE_BITS);

    localparam int MS_PER_MINUTE   = 60000;
    localparam int THRESHOLD_RESET = 2000;
    localparam int MIN_RR_RESET    = 300;

    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_PEAK_THRESHOLD = CFG_IDX_BITS'(0);
    localparam t_cfg_idx CFG_MIN_RR_MS      = CFG_IDX_BITS'(1);

    // One classified sample as it travels from the front end to the rate unit.
    typedef struct packed {
        logic                 counted;
        logic [TIME_BITS-1:0] interval;
        logic                 lead_off;
    } t_job;

endpackage

FILE: rtl/ecgrhr_in_if.sv
// Input channel of the detector: one ECG sample with its timestamp and lead pins.
`timescale 1ns / 1ps
interface ecgrhr_in_if #(
    parameter int SAMPLE_BITS = ecgrhr_pkg::SAMPLE_BITS_DEF
);
    import ecgrhr_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic [TIME_BITS-1:0]   time_ms;
    logic                   lead_plus_off;
    logic                   lead_minus_off;

    modport source (output valid, sample, time_ms, lead_plus_off, lead_minus_off,
                    input ready);
    modport sink   (input valid, sample, time_ms, lead_plus_off, lead_minus_off,
                    output ready);
endinterface

FILE: rtl/ecgrhr_out_if.sv
// Output channel of the detector: heart rate, counted-peak flag and lead-off flag.
`timescale 1ns / 1ps
interface ecgrhr_out_if;
    import ecgrhr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [RATE_BITS-1:0] heart_rate_bpm;
    logic                 peak_counted;
    logic                 lead_off;

    modport source (output valid, heart_rate_bpm, peak_counted, lead_off, input ready);
    modport sink   (input valid, heart_rate_bpm, peak_counted, lead_off, output ready);
endinterface

FILE: rtl/ecgrhr_front.sv
// Front end: configuration registers, threshold crossing and RR-interval check.
`timescale 1ns / 1ps
module ecgrhr_front #(
    parameter int SAMPLE_BITS = ecgrhr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  ecgrhr_pkg::t_cfg_idx                 i_cfg_idx,
    input  logic [ecgrhr_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    ecgrhr_in_if.sink                            i_smp,
    output logic                                 o_push_valid,
    input  logic                                 i_push_ready,
    output ecgrhr_pkg::t_job                     o_push_data
);
    import ecgrhr_pkg::*;

    localparam int TW = (SAMPLE_BITS < THR_BITS) ? SAMPLE_BITS : THR_BITS;

    logic [SAMPLE_BITS-1:0] r_thr;
    logic [MINRR_BITS-1:0]  r_min_rr;
    logic [SAMPLE_BITS-1:0] r_prev;
    logic [TIME_BITS-1:0]   r_last;

    logic                 crossing;
    logic [TIME_BITS-1:0] interval;
    logic                 counted;
    logic                 accept;

    assign crossing = (i_smp.sample > r_thr) && (r_prev < r_thr);
    assign interval = i_smp.time_ms - r_last;
    assign counted  = crossing && (interval > TIME_BITS'(r_min_rr));
    assign accept   = i_smp.valid && i_push_ready;

    assign i_smp.ready          = i_push_ready;
    assign o_push_valid         = i_smp.valid;
    assign o_push_data.counted  = counted;
    assign o_push_data.interval = interval;
    assign o_push_data.lead_off = i_smp.lead_plus_off | i_smp.lead_minus_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= SAMPLE_BITS'(THR_BITS'(THRESHOLD_RESET));
            r_min_rr <= MINRR_BITS'(MIN_RR_RESET);
            r_prev   <= '0;
            r_last   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_PEAK_THRESHOLD: r_thr    <= SAMPLE_BITS'(i_cfg_data[TW-1:0]);
                    CFG_MIN_RR_MS:      r_min_rr <= i_cfg_data[MINRR_BITS-1:0];
                endcase
            end
            if (accept) begin
                r_prev <= i_smp.sample;
                if (counted) begin
                    r_last <= i_smp.time_ms;
                end
            end
        end
    end

endmodule

FILE: rtl/ecgrhr_fifo.sv
// Short queue of classified samples between the front end and the rate unit.
`timescale 1ns / 1ps
module ecgrhr_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  ecgrhr_pkg::t_job  i_push_data,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output ecgrhr_pkg::t_job  o_pop_data
);
    import ecgrhr_pkg::*;

    t_job                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr;
    logic [QUEUE_AW-1:0]   r_rd;
    logic [QUEUE_AW:0]     r_cnt;

    logic push;
    logic pop;

    assign o_push_ready = (r_cnt != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/ecgrhr_back.sv
// Rate unit: bit-serial division of a minute by the RR interval and the output register.
`timescale 1ns / 1ps
module ecgrhr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_pop_valid,
    output logic             o_pop_ready,
    input  ecgrhr_pkg::t_job i_pop_data,
    ecgrhr_out_if.source     o_res
);
    import ecgrhr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]              r_state, n_state;
    logic [RATE_BITS-1:0]    r_rate,  n_rate;
    logic                    r_ovalid, n_ovalid;
    logic                    r_opeak, n_opeak;
    logic                    r_olead, n_olead;
    logic                    r_lead,  n_lead;
    logic [TIME_BITS-1:0]    r_div,   n_div;
    logic [RATE_BITS-1:0]    r_quo,   n_quo;
    logic [RATE_BITS-1:0]    r_rem,   n_rem;
    logic [DIV_CNT_BITS-1:0] r_cnt,   n_cnt;

    logic                 slot_free;
    logic [RATE_BITS:0]   trial;
    logic [TIME_BITS-1:0] trial_x;

    assign slot_free = !r_ovalid || o_res.ready;
    assign trial     = {r_rem, r_quo[RATE_BITS-1]};
    assign trial_x   = TIME_BITS'(trial);

    assign o_res.valid          = r_ovalid;
    assign o_res.heart_rate_bpm = r_rate;
    assign o_res.peak_counted   = r_opeak;
    assign o_res.lead_off       = r_olead;

    always_comb begin
        n_state     = r_state;
        n_rate      = r_rate;
        n_ovalid    = r_ovalid && !o_res.ready;
        n_opeak     = r_opeak;
        n_olead     = r_olead;
        n_lead      = r_lead;
        n_div       = r_div;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        o_pop_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_pop_valid) begin
                    if (i_pop_data.counted) begin
                        o_pop_ready = 1'b1;
                        n_div       = i_pop_data.interval;
                        n_quo       = RATE_BITS'(MS_PER_MINUTE);
                        n_rem       = '0;
                        n_cnt       = '1;
                        n_lead      = i_pop_data.lead_off;
                        n_state     = S_DIV;
                    end else if (slot_free) begin
                        o_pop_ready = 1'b1;
                        n_ovalid    = 1'b1;
                        n_opeak     = 1'b0;
                        n_olead     = i_pop_data.lead_off;
                    end
                end
            end
            S_DIV: begin
                // One restoring-division step: quotient bits enter from the right.
                if (trial_x >= r_div) begin
                    n_rem = RATE_BITS'(trial_x - r_div);
                    n_quo = {r_quo[RATE_BITS-2:0], 1'b1};
                end else begin
                    n_rem = trial[RATE_BITS-1:0];
                    n_quo = {r_quo[RATE_BITS-2:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    n_rate   = r_quo;
                    n_ovalid = 1'b1;
                    n_opeak  = 1'b1;
                    n_olead  = r_lead;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rate   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rate   <= n_rate;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_opeak <= n_opeak;
        r_olead <= n_olead;
        r_lead  <= n_lead;
        r_div   <= n_div;
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_cnt   <= n_cnt;
    end

endmodule

FILE: rtl/ecg_r_peak_heart_rate_top.sv
// Top level of the ECG R-peak heart-rate detector.
//
// Usage: each item on i_smp carries one converter sample, its millisecond
// timestamp and the two lead-off pin levels; an item is taken when valid and
// ready are both high. For every input item exactly one result item leaves on
// o_res, in order: the current heart rate, a flag for a counted R-peak and the
// OR of the lead-off pins. The configuration port (i_cfg_we, i_cfg_idx,
// i_cfg_data) writes the threshold or the minimum RR interval; it is meant
// to be used only while no item is in flight. A plain sample moves from the
// queue into the output register; a counted peak moves into the divider,
// runs 16 divider steps for 60000 / interval, then goes to the output register.
// Flow: the front end takes one item per cycle into a two-entry queue while
// it has room; the rate unit clears one plain sample per cycle while the
// output register is free and takes no new item while it divides, so the
// sustained rate is one item per cycle between peaks if the receiver keeps up.
// Reset (synchronous, active low) restores the default threshold and minimum
// interval, clears the previous sample, last peak time and rate, and empties
// the queue. When the receiver stalls, the result waits in the output register,
// the queue fills, and then i_smp.ready falls until the output is taken.
`timescale 1ns / 1ps
module ecg_r_peak_heart_rate_top #(
    parameter int SAMPLE_BITS = ecgrhr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  ecgrhr_pkg::t_cfg_idx                 i_cfg_idx,
    input  logic [ecgrhr_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    ecgrhr_in_if.sink                            i_smp,
    ecgrhr_out_if.source                         o_res
);
    import ecgrhr_pkg::*;

    // Classified samples flow from the front end through the queue.
    logic q_push_valid;
    logic q_push_ready;
    t_job q_push_data;
    logic q_pop_valid;
    logic q_pop_ready;
    t_job q_pop_data;

    // Threshold crossing and RR check happen here, so the last peak time is
    // settled before the next sample arrives and the divider never holds it up.
    ecgrhr_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_smp        (i_smp),
        .o_push_valid (q_push_valid),
        .i_push_ready (q_push_ready),
        .o_push_data  (q_push_data)
    );

    ecgrhr_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (q_push_valid),
        .o_push_ready (q_push_ready),
        .i_push_data  (q_push_data),
        .o_pop_valid  (q_pop_valid),
        .i_pop_ready  (q_pop_ready),
        .o_pop_data   (q_pop_data)
    );

    // The rate unit keeps the heart rate and owns the output register.
    ecgrhr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (q_pop_valid),
        .o_pop_ready (q_pop_ready),
        .i_pop_data  (q_pop_data),
        .o_res       (o_res)
    );

    // A counted peak must never reach the divider with a zero interval.
    a_no_zero_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_pop_valid && q_pop_ready && q_pop_data.counted) |-> (q_pop_data.interval != '0))
        else $error("counted peak with zero interval reached the divider");

    // The divider result can never exceed one minute in milliseconds.
    a_rate_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.heart_rate_bpm <= RATE_BITS'(MS_PER_MINUTE)))
        else $error("heart rate above 60000");

    // A sample that is not a counted peak leaves the rate unchanged.
    a_rate_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.peak_counted) |-> $stable(o_res.heart_rate_bpm))
        else $error("heart rate changed without a counted peak");

endmodule

FILE: tb/ecgrhr_rate_checker.sv
// Checker for the ECG R-peak heart-rate detector: predicts each result and compares it.
`timescale 1ns / 1ps
module ecgrhr_rate_checker
    import ecgrhr_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  t_cfg_idx                 i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    ecgrhr_in_if                     i_smp,
    ecgrhr_out_if                    i_res,
    output int                       o_fail_count,
    output int                       o_pending
);

    localparam int REPORT_CAP = 200;

    typedef struct packed {
        logic [RATE_BITS-1:0] bpm;
        logic                 counted;
        logic                 lead_off;
    } t_beat_result;

    // Mirror of the detector state and its two registers.
    logic [SAMPLE_BITS_DEF-1:0] prev_level;
    logic [TIME_BITS-1:0]       last_beat_ms;
    logic [RATE_BITS-1:0]       bpm_now;
    logic [THR_BITS-1:0]        thr_level;
    logic [MINRR_BITS-1:0]      min_interval_ms;

    t_beat_result beats_due[$];
    int           fails;
    int           reports;

    function automatic t_beat_result predict_beat(logic [SAMPLE_BITS_DEF-1:0] level,
                                                  logic [TIME_BITS-1:0] stamp,
                                                  logic lead_p, logic lead_m);
        t_beat_result         r;
        logic [TIME_BITS-1:0] rr;
        r.counted = 1'b0;
        if (level > thr_level && prev_level < thr_level) begin
            rr = stamp - last_beat_ms;
            if (rr > TIME_BITS'(min_interval_ms)) begin
                last_beat_ms = stamp;
                bpm_now      = RATE_BITS'(TIME_BITS'(MS_PER_MINUTE) / rr);
                r.counted    = 1'b1;
            end
        end
        prev_level = level;
        r.bpm      = bpm_now;
        r.lead_off = lead_p | lead_m;
        return r;
    endfunction

    task automatic report(string what, t_beat_result want, t_beat_result got);
        if (reports < REPORT_CAP) begin
            $display("%0t: %s: expected bpm=%0d peak=%0b lead_off=%0b, %s",
                     $time, what, want.bpm, want.counted, want.lead_off,
                     $sformatf("got bpm=%0d peak=%0b lead_off=%0b",
                               got.bpm, got.counted, got.lead_off));
        end
        reports++;
    endtask

    initial begin
        fails   = 0;
        reports = 0;
    end

    always @(posedge i_clk) begin
        t_beat_result got;
        t_beat_result want;
        if (!i_rst_n) begin
            prev_level      = '0;
            last_beat_ms    = '0;
            bpm_now         = '0;
            thr_level       = THR_BITS'(THRESHOLD_RESET);
            min_interval_ms = MINRR_BITS'(MIN_RR_RESET);
            beats_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PEAK_THRESHOLD: thr_level       = i_cfg_data[THR_BITS-1:0];
                    CFG_MIN_RR_MS:      min_interval_ms = i_cfg_data[MINRR_BITS-1:0];
                    default: ;
                endcase
            end
            // A result can never belong to the item taken at the same edge, so the
            // comparison runs before the new prediction is queued.
            if (i_res.valid && i_res.ready) begin
                got = '{i_res.heart_rate_bpm, i_res.peak_counted, i_res.lead_off};
                if (beats_due.size() == 0) begin
                    report("result with nothing expected", '0, got);
                    fails++;
                end else begin
                    want = beats_due.pop_front();
                    if (got !== want) begin
                        report("result mismatch", want, got);
                        fails++;
                    end
                end
            end
            if (i_smp.valid && i_smp.ready) begin
                beats_due.push_back(predict_beat(i_smp.sample, i_smp.time_ms,
                                                 i_smp.lead_plus_off, i_smp.lead_minus_off));
            end
        end
        o_pending    <= beats_due.size();
        o_fail_count <= fails;
    end

endmodule

FILE: tb/tb_ecg_r_peak_heart_rate_top.sv
// Testbench top for the ECG R-peak heart-rate detector: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb_ecg_r_peak_heart_rate_top;
    import ecgrhr_pkg::*;

    // Largest converter level at the default sample width.
    localparam int LEVEL_MAX = (1 << SAMPLE_BITS_DEF) - 1;
    // Total item count after which the random phases stop.
    localparam int ITEM_GOAL = 920;
    // Extra cycles waited after the last result has been taken.
    localparam int DRAIN_CYCLES = 40;

    // Receiver behavior: always ready, ready on a coin toss, or mostly stalled.
    typedef enum {RX_FREE, RX_CHOPPY, RX_SLOW} t_rx_mode;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    t_cfg_idx                 i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    ecgrhr_in_if  smp_if();
    ecgrhr_out_if res_if();

    int fail_count;
    int pending;

    ecg_r_peak_heart_rate_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_smp      (smp_if),
        .o_res      (res_if)
    );

    // The checker watches both channels and the register port on its own; the
    // top only learns how many results are still due and how many went wrong.
    ecgrhr_rate_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_smp        (smp_if),
        .i_res        (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Stimulus-side copy of the registers, used only to shape the samples and
    // timestamps so that crossings and interval boundaries are hit often.
    logic [THR_BITS-1:0]   thr_cur;
    logic [MINRR_BITS-1:0] min_rr_cur;
    logic [TIME_BITS-1:0]  beat_ms;
    int                    sent_items;
    int                    burst_left;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Safety net: a healthy run needs well under a tenth of this time.
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // The receiver switches between its modes at random, so stalls land on every
    // phase of the divider and the queue.
    initial begin : receiver_stalls
        t_rx_mode mode;
        int       left;
        res_if.ready <= 1'b0;
        mode = RX_FREE;
        left = 0;
        forever begin
            @(posedge i_clk);
            if (left == 0) begin
                mode = t_rx_mode'($urandom_range(0, 2));
                left = $urandom_range(20, 200);
            end
            left--;
            case (mode)
                RX_FREE:   res_if.ready <= 1'b1;
                RX_CHOPPY: res_if.ready <= 1'($urandom_range(0, 1));
                default:   res_if.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Hands one item to the block. The sender works in bursts; when a burst is
    // used up, valid drops for a short random gap before the next one starts.
    // Valid stays high between items of a burst, so it is never lowered and
    // raised within the same time step.
    task automatic send_sample(input logic [SAMPLE_BITS_DEF-1:0] level,
                               input logic [TIME_BITS-1:0] stamp,
                               input logic lead_p, input logic lead_m);
        if (burst_left == 0) begin
            smp_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            // One burst in four is long, which gives stretches with no idling.
            if ($urandom_range(0, 3) == 0) begin
                burst_left = $urandom_range(40, 120);
            end else begin
                burst_left = $urandom_range(1, 12);
            end
        end
        burst_left--;
        smp_if.valid          <= 1'b1;
        smp_if.sample         <= level;
        smp_if.time_ms        <= stamp;
        smp_if.lead_plus_off  <= lead_p;
        smp_if.lead_minus_off <= lead_m;
        do @(posedge i_clk); while (!smp_if.ready);
        sent_items++;
    endtask

    // Stops sending and waits until every expected result has been taken. The
    // first edge is always waited out so that the count reflects the last item.
    task automatic wait_drained();
        smp_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes both registers on back-to-back edges while the block is idle. The
    // threshold write carries random bits above the 12-bit field, which the
    // block must ignore.
    task automatic set_registers(input logic [THR_BITS-1:0] thr,
                                 input logic [MINRR_BITS-1:0] min_rr);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_PEAK_THRESHOLD;
        i_cfg_data <= {4'($urandom_range(0, 15)), thr};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MIN_RR_MS;
        i_cfg_data <= min_rr;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        thr_cur    = thr;
        min_rr_cur = min_rr;
    endtask

    function automatic logic [SAMPLE_BITS_DEF-1:0] below_level();
        if (thr_cur == 0) begin
            return '0;
        end
        return SAMPLE_BITS_DEF'($urandom_range(0, int'(thr_cur) - 1));
    endfunction

    function automatic logic [SAMPLE_BITS_DEF-1:0] above_level();
        if (thr_cur == LEVEL_MAX) begin
            return SAMPLE_BITS_DEF'(LEVEL_MAX);
        end
        return SAMPLE_BITS_DEF'($urandom_range(int'(thr_cur) + 1, LEVEL_MAX));
    endfunction

    // Leads are attached most of the time; either pin may drop out.
    function automatic logic lead_pin();
        return ($urandom_range(0, 3) == 0);
    endfunction

    // One heartbeat: a few samples below the threshold (now and then one
    // sitting exactly on it), then a sample above it. The peak timestamp is
    // placed at the minimum interval plus an offset, often small, so the strict
    // interval test is probed right at its edge as well as well past it.
    task automatic send_beat();
        int                   n_low;
        int                   offset;
        logic [TIME_BITS-1:0] peak_ms;
        n_low = $urandom_range(1, 4);
        case ($urandom_range(0, 7))
            0:       offset = 0;
            1:       offset = 1;
            2:       offset = -1;
            3:       offset = 2;
            default: offset = $urandom_range(3, 3000);
        endcase
        peak_ms = beat_ms + TIME_BITS'(min_rr_cur) + TIME_BITS'(offset);
        for (int i = 0; i < n_low; i++) begin
            send_sample(($urandom_range(0, 9) == 0) ? thr_cur : below_level(),
                        beat_ms + TIME_BITS'(i), lead_pin(), lead_pin());
        end
        send_sample(above_level(), peak_ms, lead_pin(), lead_pin());
        // A plateau above the threshold must not count a second time.
        if ($urandom_range(0, 3) == 0) begin
            send_sample(above_level(), peak_ms + 1, lead_pin(), lead_pin());
        end
        beat_ms = peak_ms;
    endtask

    // A sample and a timestamp drawn over the full range; it may jump the clock
    // backwards or far ahead, which the interval arithmetic must wrap through.
    task automatic send_noise();
        logic [TIME_BITS-1:0] stamp;
        stamp = $urandom();
        send_sample(SAMPLE_BITS_DEF'($urandom_range(0, LEVEL_MAX)), stamp,
                    lead_pin(), lead_pin());
        if ($urandom_range(0, 1) == 0) begin
            beat_ms = stamp;
        end
    endtask

    // One random phase: the block is drained, both registers are written, and
    // then mostly well-formed heartbeats follow with some noise mixed in.
    task automatic run_phase(input logic [THR_BITS-1:0] thr,
                             input logic [MINRR_BITS-1:0] min_rr, input int n_items);
        int stop_at;
        wait_drained();
        set_registers(thr, min_rr);
        stop_at = sent_items + n_items;
        while (sent_items < stop_at) begin
            if ($urandom_range(0, 99) < 85) begin
                send_beat();
            end else begin
                send_noise();
            end
        end
    endtask

    initial begin : stimulus
        logic [MINRR_BITS-1:0] min_rr;
        i_rst_n               <= 1'b0;
        i_cfg_we              <= 1'b0;
        i_cfg_idx             <= CFG_PEAK_THRESHOLD;
        i_cfg_data            <= '0;
        smp_if.valid          <= 1'b0;
        smp_if.sample         <= '0;
        smp_if.time_ms        <= '0;
        smp_if.lead_plus_off  <= 1'b0;
        smp_if.lead_minus_off <= 1'b0;
        thr_cur    = THR_BITS'(THRESHOLD_RESET);
        min_rr_cur = MINRR_BITS'(MIN_RR_RESET);
        beat_ms    = '0;
        sent_items = 0;
        burst_left = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset values (threshold 2000, minimum 300 ms).
        // A crossing too soon after the reset time of zero is not counted.
        send_sample(0, 0, 1'b0, 1'b0);
        send_sample(LEVEL_MAX, 100, 1'b0, 1'b0);
        send_sample(0, 200, 1'b1, 1'b0);
        // A sample equal to the threshold neither ends nor starts a crossing.
        send_sample(2000, 400, 1'b0, 1'b1);
        send_sample(LEVEL_MAX, 500, 1'b1, 1'b1);
        // Just below to just above: counted, 60 beats per minute.
        send_sample(1999, 600, 1'b0, 1'b0);
        send_sample(2001, 1000, 1'b0, 1'b0);
        // One millisecond over the minimum counts; exactly the minimum does not.
        send_sample(0, 1100, 1'b0, 1'b0);
        send_sample(LEVEL_MAX, 1301, 1'b1, 1'b0);
        send_sample(1999, 1400, 1'b0, 1'b0);
        send_sample(LEVEL_MAX, 1601, 1'b0, 1'b0);
        // The clock goes backwards: a huge wrapped interval gives a rate of zero.
        send_sample(0, 1700, 1'b0, 1'b0);
        send_sample(LEVEL_MAX, 50, 1'b0, 1'b1);
        send_sample(0, 32'hFFFF_FFFF, 1'b0, 1'b0);
        send_sample(LEVEL_MAX, 32'hFFFF_FFFF, 1'b1, 1'b1);

        // Threshold 1 and a zero minimum: one millisecond gives the top rate of
        // 60000, and a zero interval never counts.
        wait_drained();
        set_registers(1, 0);
        send_sample(0, 1000, 1'b0, 1'b0);
        send_sample(2, 1001, 1'b0, 1'b0);
        send_sample(0, 1001, 1'b0, 1'b0);
        send_sample(2, 1002, 1'b0, 1'b0);
        send_sample(0, 1002, 1'b0, 1'b0);
        send_sample(2, 1002, 1'b0, 1'b0);
        send_sample(1, 1003, 1'b0, 1'b0);
        send_sample(2, 1004, 1'b0, 1'b0);
        beat_ms = 1002;

        // Register extremes: no crossing can happen at either end of the range,
        // and the widest minimum interval.
        run_phase(THR_BITS'(LEVEL_MAX), 0, 60);
        run_phase(0, 16'hFFFF, 60);
        run_phase(THR_BITS'($urandom_range(1, LEVEL_MAX - 1)), 16'hFFFF, 100);

        // Random settings until enough items have gone through. Most minimum
        // intervals are small so that rates spread over the useful range.
        while (sent_items < ITEM_GOAL) begin
            if ($urandom_range(0, 4) == 0) begin
                min_rr = MINRR_BITS'($urandom_range(0, 16'hFFFF));
            end else begin
                min_rr = MINRR_BITS'($urandom_range(0, 1000));
            end
            run_phase(THR_BITS'($urandom_range(0, LEVEL_MAX)), min_rr, 120);
        end

        wait_drained();
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/ecgrhr_pkg.sv
rtl/ecgrhr_in_if.sv
rtl/ecgrhr_out_if.sv
rtl/ecgrhr_front.sv
rtl/ecgrhr_fifo.sv
rtl/ecgrhr_back.sv
rtl/ecg_r_peak_heart_rate_top.sv
tb/ecgrhr_rate_checker.sv
tb/tb_ecg_r_peak_heart_rate_top.sv
